### design/brf_pkg.sv
// Package for the chunked circular byte FIFO.
// Holds the sizing constants, the mode and status codes and the beat types.
// Used by brf_ctrl and byte_ring_fifo_chunked_top; has no dependencies.
package brf_pkg;

  // Sizing of the byte store and the request chunk.
  localparam int DEPTH     = 256;
  localparam int MAX_CHUNK = 8;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int LEN_W     = 4;
  localparam int LANE_W    = 3;
  localparam int DATA_W    = 64;

  // Request modes.
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [1:0]        mode;
    logic [LEN_W-1:0]  byte_count;
    logic [DATA_W-1:0] push_bytes;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [DATA_W-1:0] read_bytes;
    logic [1:0]        status;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
  } out_item_t;

  // Byte store access from the controller.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

### design/brf_byte_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Generic; used as the byte store of the FIFO. No package dependencies.
module brf_byte_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/brf_ctrl.sv
// Request sequencer of the byte FIFO: pointers, fill count and byte moves.
// Depends on brf_pkg and drives the byte store through a brf_pkg::mem_req_t.
module brf_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  brf_pkg::in_item_t        in_data,
  input  logic                     cfg_we,
  input  logic [brf_pkg::CNT_W-1:0] cap,
  output brf_pkg::mem_req_t        mem_req,
  input  logic [7:0]               mem_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output brf_pkg::out_item_t       res_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [1:0]                      mode_r, mode_nxt;
  logic [brf_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [brf_pkg::DATA_W-1:0]      data_r, data_nxt;
  logic [brf_pkg::DATA_W-1:0]      rd_r, rd_nxt;
  logic [1:0]                      status_r, status_nxt;
  logic [brf_pkg::PTR_W-1:0]       rp_r, rp_nxt;
  logic [brf_pkg::PTR_W-1:0]       wp_r, wp_nxt;
  logic [brf_pkg::PTR_W-1:0]       p_r, p_nxt;
  logic [brf_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [brf_pkg::LEN_W-1:0]       step_r, step_nxt;
  logic [brf_pkg::LANE_W-1:0]      lane_r, lane_nxt;
  logic                            rvalid_r, rvalid_nxt;

  logic [brf_pkg::LEN_W-1:0]       req_len;
  logic [brf_pkg::CNT_W-1:0]       free_now;
  logic [brf_pkg::LEN_W-1:0]       len_last;

  // Step a pointer by one slot, wrapping at the capacity.
  function automatic logic [brf_pkg::PTR_W-1:0] advance(
    input logic [brf_pkg::PTR_W-1:0] p,
    input logic [brf_pkg::CNT_W-1:0] c
  );
    logic [brf_pkg::CNT_W-1:0] inc;
    inc = {1'b0, p} + 1'b1;
    return (inc >= c) ? '0 : inc[brf_pkg::PTR_W-1:0];
  endfunction

  // Saturate the requested length to the chunk size.
  assign req_len  = (in_data.byte_count > brf_pkg::LEN_W'(brf_pkg::MAX_CHUNK)) ?
                    brf_pkg::LEN_W'(brf_pkg::MAX_CHUNK) : in_data.byte_count;
  assign free_now = cap - cnt_r;
  assign len_last = len_r - 1'b1;

  // Result fields come straight from the registers while in the done state.
  assign res_valid           = (state_r == ST_DONE);
  assign res_data.read_bytes = rd_r;
  assign res_data.status     = status_r;
  assign res_data.fill_level = cnt_r;
  assign res_data.free_space = cap - cnt_r;
  assign in_ready            = (state_r == ST_IDLE);

  // Sequencer: per cycle, ST_WRITE writes a byte and ST_READ issues a read.
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    data_nxt   = data_r;
    rd_nxt     = rd_r;
    status_nxt = status_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    p_nxt      = p_r;
    cnt_nxt    = cnt_r;
    step_nxt   = step_r;
    lane_nxt   = lane_r;
    rvalid_nxt = 1'b0;
    mem_req    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_data.mode;
          len_nxt    = req_len;
          data_nxt   = in_data.push_bytes;
          rd_nxt     = '0;
          status_nxt = brf_pkg::STATUS_DONE;
          p_nxt      = rp_r;
          step_nxt   = '0;
          lane_nxt   = '0;
          state_nxt  = ST_DONE;
          unique case (in_data.mode) inside
            brf_pkg::MODE_PUSH: begin
              if (brf_pkg::CNT_W'(req_len) > free_now) begin
                status_nxt = brf_pkg::STATUS_OVERFLOW;
              end else if (req_len != '0) begin
                state_nxt = ST_WRITE;
              end
            end
            brf_pkg::MODE_POP, brf_pkg::MODE_PEEK: begin
              if (brf_pkg::CNT_W'(req_len) > cnt_r) begin
                status_nxt = brf_pkg::STATUS_UNDERFLOW;
              end else if (req_len != '0) begin
                state_nxt = ST_READ;
              end
            end
            brf_pkg::MODE_CLEAR: begin
              rp_nxt  = '0;
              wp_nxt  = '0;
              cnt_nxt = '0;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_WRITE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wp_r;
        mem_req.wdata = data_r[7:0];
        data_nxt      = data_r >> 8;
        wp_nxt        = advance(wp_r, cap);
        step_nxt      = step_r + 1'b1;
        if (step_r == len_last) begin
          cnt_nxt   = cnt_r + brf_pkg::CNT_W'(len_r);
          state_nxt = ST_DONE;
        end
      end

      ST_READ: begin
        // Issue side: one address per cycle until all are out.
        if (step_r < len_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = p_r;
          p_nxt         = advance(p_r, cap);
          step_nxt      = step_r + 1'b1;
          rvalid_nxt    = 1'b1;
        end
        // Return side: data lands in the cycle after its address.
        if (rvalid_r) begin
          rd_nxt[{lane_r, 3'b000} +: 8] = mem_rdata;
          lane_nxt = lane_r + 1'b1;
          if ({1'b0, lane_r} == len_last) begin
            if (mode_r == brf_pkg::MODE_POP) begin
              rp_nxt  = p_r;
              cnt_nxt = cnt_r - brf_pkg::CNT_W'(len_r);
            end
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A capacity write empties the buffer.
    if (cfg_we) begin
      rp_nxt  = '0;
      wp_nxt  = '0;
      cnt_nxt = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rp_r     <= '0;
      wp_r     <= '0;
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      rvalid_r <= rvalid_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    len_r    <= len_nxt;
    data_r   <= data_nxt;
    rd_r     <= rd_nxt;
    status_r <= status_nxt;
    p_r      <= p_nxt;
    step_r   <= step_nxt;
    lane_r   <= lane_nxt;
  end

endmodule

### design/byte_ring_fifo_chunked_top.sv
// Chunked circular byte FIFO, top level: capacity register and result stage.
// One request at a time: clear, refused or empty requests go straight to the
// result; a push writes its bytes one by one and a pop or peek reads them one
// by one through the byte-wide store, and each result passes the output register.
// Reset (rst_n, synchronous): empty buffer, capacity 256; store contents stay.
module byte_ring_fifo_chunked_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  brf_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output brf_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic [brf_pkg::CNT_W-1:0] cfg_wdata
);

  logic [brf_pkg::CNT_W-1:0] cap_r;
  logic [brf_pkg::CNT_W-1:0] cap_eff;
  brf_pkg::mem_req_t         mem_req;
  logic [7:0]                mem_rdata;
  logic                      res_valid;
  logic                      res_ready;
  brf_pkg::out_item_t        res_data;
  logic                      out_valid_r;
  brf_pkg::out_item_t        out_r;

  // Capacity register; zero acts as one slot, oversize values as the full store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= brf_pkg::CNT_W'(brf_pkg::DEPTH);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_eff = (cap_r == '0) ? brf_pkg::CNT_W'(1) :
                   (cap_r > brf_pkg::CNT_W'(brf_pkg::DEPTH)) ?
                   brf_pkg::CNT_W'(brf_pkg::DEPTH) : cap_r;

  // Byte store.
  brf_byte_ram #(
    .DATA_W (8),
    .ADDR_W (brf_pkg::PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Request sequencer.
  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cap       (cap_eff),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // Output register: frees the sequencer while a result beat waits.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
